// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on each rising clk edge, skipped while rst_n is low
`define RPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on each rising clk edge, including during reset
`define RPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/rpa_pkg.sv =====
// Package: types, codes and constants of the reference point association block
`default_nettype none
package rpa_pkg;

  localparam int MAX_REFS_DEF   = 256;
  localparam int MAX_OBJ_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;

  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 120;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 9;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_POINT = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam logic [CFG_ADDR_W-1:0] CFG_NUM_OBJ   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_REF_FIRST = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_REF_LIMIT = 2'd2;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_REF_START,
    S_K1_RD,
    S_K1_MUL,
    S_K1_ACC,
    S_NORM_CHK,
    S_DIV_SAT,
    S_DIV,
    S_DIV_END,
    S_K2_RD,
    S_K2_MUL,
    S_K2_DIFF,
    S_K2_SQ,
    S_K2_ACC,
    S_SQRT,
    S_PICK,
    S_NEXT_REF,
    S_FINISH,
    S_CNT_UPD
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic clr_init;
    logic clr_step;
    logic ref_init;
    logic k_clr;
    logic rd_ref;
    logic mul;
    logic mul_t;
    logic acc1;
    logic abs_dot;
    logic t_sat;
    logic div_init;
    logic div_step;
    logic t_div;
    logic diff;
    logic sq;
    logic acc2;
    logic sqrt_init;
    logic sqrt_step;
    logic pick;
    logic next_ref;
    logic cnt_rd;
    logic cnt_upd;
    logic load_empty;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    req_t in_req;
    logic in_last;
    logic clr_last;
    logic ref_end;
    logic k_end;
    logic norm_zero;
    logic div_sat;
    logic div_last;
    logic sqrt_last;
    logic found;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/reference_point_association_top.sv =====
// Top level: reference point association, controller plus datapath
// Takes one word per cycle in idle. A point's final coordinate starts a scan of
// references [ref_first, min(ref_limit, MAX_REFS)); each usable reference goes
// through a 31-step divider and a 32-step square root unit, a reference whose
// projection saturates skips the divider, and a zero-length one is skipped; the
// result then waits for any stall on the output.
// After reset, and after a clear-counts word, a clearing pass runs through all
// MAX_REFS entries of the count memory with in_tready low.
`default_nettype none
`include "assert_macros.svh"
module reference_point_association_top #(
  parameter int MAX_REFS   = rpa_pkg::MAX_REFS_DEF,
  parameter int MAX_OBJ    = rpa_pkg::MAX_OBJ_DEF,
  parameter int COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [rpa_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [rpa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // ref_index, obj_index, coord_value, from_archive
  input  wire logic [rpa_pkg::IN_TDATA_W-1:0] in_tdata,
  // req_type
  input  wire logic [rpa_pkg::IN_TUSER_W-1:0] in_tuser,
  input  wire logic                           in_tlast,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // assoc_ref, perp_distance, projection, total_count, archive_count, front_count
  output logic [rpa_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // status
  output logic                                out_tuser
);
  import rpa_pkg::*;

  cmd_t   cmd;
  sts_t   sts;
  state_t state;

  rpa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd),
    .state (state)
  );

  rpa_dp #(
    .MAX_REFS   (MAX_REFS),
    .MAX_OBJ    (MAX_OBJ),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  assign in_tready = cmd.in_ready;

  `RPA_ASSERT(a_empty_zero, (out_tvalid && out_tuser) |-> (out_tdata == '0), "status word not zero")
  `RPA_ASSERT(a_clear_stall, (state == S_CLEAR) |-> !in_tready, "input taken while clearing")
  `RPA_ASSERT(a_scan_stall, (in_tvalid && in_tready && in_tuser == REQ_POINT && in_tlast) |=> !in_tready, "input taken during scan")
  `RPA_ASSERT_ALWAYS(a_one_cmd, !(cmd.clr_step && cmd.cnt_upd), "count memory double write")

endmodule
`default_nettype wire

// ===== src/rpa_ctrl.sv =====
// Controller: sequences reference scan, division, distance and count update
`default_nettype none
module rpa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rpa_pkg::sts_t sts,
  output rpa_pkg::cmd_t      cmd,
  output rpa_pkg::state_t    state
);
  import rpa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          priority if (sts.in_req == REQ_CLEAR) begin
            cmd.clr_init = 1'b1;
            state_nxt    = S_CLEAR;
          end else if (sts.in_req == REQ_POINT && sts.in_last) begin
            cmd.ref_init = 1'b1;
            state_nxt    = S_REF_START;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_REF_START: begin
        if (sts.ref_end) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.k_clr = 1'b1;
          state_nxt = S_K1_RD;
        end
      end
      S_K1_RD: begin
        if (sts.k_end) begin
          state_nxt = S_NORM_CHK;
        end else begin
          cmd.rd_ref = 1'b1;
          state_nxt  = S_K1_MUL;
        end
      end
      S_K1_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_K1_ACC;
      end
      S_K1_ACC: begin
        cmd.acc1  = 1'b1;
        state_nxt = S_K1_RD;
      end
      S_NORM_CHK: begin
        if (sts.norm_zero) begin
          state_nxt = S_NEXT_REF;
        end else begin
          cmd.abs_dot = 1'b1;
          state_nxt   = S_DIV_SAT;
        end
      end
      S_DIV_SAT: begin
        if (sts.div_sat) begin
          cmd.t_sat = 1'b1;
          state_nxt = S_K2_RD;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_DIV_END;
      end
      S_DIV_END: begin
        cmd.t_div = 1'b1;
        state_nxt = S_K2_RD;
      end
      S_K2_RD: begin
        if (sts.k_end) begin
          cmd.sqrt_init = 1'b1;
          state_nxt     = S_SQRT;
        end else begin
          cmd.rd_ref = 1'b1;
          state_nxt  = S_K2_MUL;
        end
      end
      S_K2_MUL: begin
        cmd.mul   = 1'b1;
        cmd.mul_t = 1'b1;
        state_nxt = S_K2_DIFF;
      end
      S_K2_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_K2_SQ;
      end
      S_K2_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_K2_ACC;
      end
      S_K2_ACC: begin
        cmd.acc2  = 1'b1;
        state_nxt = S_K2_RD;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_last) state_nxt = S_PICK;
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_NEXT_REF;
      end
      S_NEXT_REF: begin
        cmd.next_ref = 1'b1;
        state_nxt    = S_REF_START;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          if (sts.found) begin
            cmd.cnt_rd = 1'b1;
            state_nxt  = S_CNT_UPD;
          end else begin
            cmd.load_empty = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end
      S_CNT_UPD: begin
        cmd.cnt_upd = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign state = state_r;

endmodule
`default_nettype wire

// ===== src/rpa_dp.sv =====
// Datapath: tables, config registers, arithmetic units and result register
`default_nettype none
module rpa_dp #(
  parameter int MAX_REFS   = rpa_pkg::MAX_REFS_DEF,
  parameter int MAX_OBJ    = rpa_pkg::MAX_OBJ_DEF,
  parameter int COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire rpa_pkg::cmd_t                     cmd,
  output rpa_pkg::sts_t                          sts,
  input  wire logic                              cfg_we,
  input  wire logic [rpa_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [rpa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                              in_tvalid,
  input  wire logic [rpa_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic [rpa_pkg::IN_TUSER_W-1:0]    in_tuser,
  input  wire logic                              in_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [rpa_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                   out_tuser
);
  import rpa_pkg::*;

  localparam int REF_W   = $clog2(MAX_REFS);
  localparam int OBJ_W   = $clog2(MAX_OBJ);
  localparam int IW      = (REF_W + 1 > 8) ? REF_W + 1 : 8;
  localparam int KW      = OBJ_W + 1;
  localparam int ACC_W   = 48 + OBJ_W;
  localparam int DIV_W   = ACC_W + 31;
  localparam int CW3     = 3 * COUNT_BITS;
  localparam int MEM_D   = MAX_REFS << OBJ_W;
  localparam logic [63:0] SUM_CAP = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // input word fields
  logic              acc_in;
  req_t              in_req;
  logic [7:0]        in_ridx;
  logic [3:0]        in_oidx;
  logic signed [31:0] in_val;
  logic              in_arch;

  assign acc_in  = in_tvalid & cmd.in_ready;
  assign in_req  = req_t'(in_tuser);
  assign in_ridx = in_tdata[7:0];
  assign in_oidx = in_tdata[11:8];
  assign in_val  = in_tdata[43:12];
  assign in_arch = in_tdata[44];

  // configuration
  logic [4:0] num_obj_r;
  logic [7:0] ref_first_r;
  logic [8:0] ref_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_obj_r   <= 5'd3;
      ref_first_r <= 8'd0;
      ref_limit_r <= 9'd256;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_NUM_OBJ)   num_obj_r   <= cfg_wdata[4:0];
      if (cfg_addr == CFG_REF_FIRST) ref_first_r <= cfg_wdata[7:0];
      if (cfg_addr == CFG_REF_LIMIT) ref_limit_r <= cfg_wdata[8:0];
    end
  end

  // loop counters
  logic [IW-1:0] i_r;
  logic [KW-1:0] k_r;
  logic          arch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      k_r <= '0;
    end else begin
      if (cmd.ref_init) i_r <= IW'(ref_first_r);
      else if (cmd.next_ref) i_r <= i_r + 1'b1;
      if (cmd.k_clr || cmd.t_sat || cmd.t_div) k_r <= '0;
      else if (cmd.acc1 || cmd.acc2) k_r <= k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in && in_req == REQ_POINT) arch_r <= in_arch;
  end

  // reference table
  logic signed [31:0] ref_mem [MEM_D];
  logic signed [31:0] rk_q;

  always_ff @(posedge clk) begin
    if (acc_in && in_req == REQ_LOAD && 32'(in_ridx) < MAX_REFS && 32'(in_oidx) < MAX_OBJ) begin
      ref_mem[{REF_W'(in_ridx), OBJ_W'(in_oidx)}] <= in_val;
    end
    if (cmd.rd_ref) rk_q <= ref_mem[{i_r[REF_W-1:0], k_r[OBJ_W-1:0]}];
  end

  // point buffer
  logic signed [31:0] pbuf_r [MAX_OBJ];
  logic signed [31:0] pk;

  always_ff @(posedge clk) begin
    if (acc_in && in_req == REQ_POINT && 32'(in_oidx) < MAX_OBJ) begin
      pbuf_r[OBJ_W'(in_oidx)] <= in_val;
    end
  end

  assign pk = pbuf_r[k_r[OBJ_W-1:0]];

  // multipliers
  logic signed [31:0] t_r;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod_r, prod2_r;

  assign mul_b = cmd.mul_t ? t_r : pk;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r  <= rk_q * mul_b;
      prod2_r <= rk_q * rk_q;
    end
  end

  // dot product and squared norm
  logic signed [ACC_W-1:0] dot_r;
  logic [ACC_W-1:0]        norm_r;

  always_ff @(posedge clk) begin
    if (cmd.k_clr) begin
      dot_r  <= '0;
      norm_r <= '0;
    end else if (cmd.acc1) begin
      dot_r  <= dot_r + ACC_W'($signed(prod_r[63:16]));
      norm_r <= norm_r + ACC_W'(prod2_r[63:16]);
    end
  end

  // projection divider
  logic               neg_r;
  logic [ACC_W-1:0]   a_r;
  logic [DIV_W-1:0]   rem_r, dv_r;
  logic [30:0]        q_r;
  logic [4:0]         step_r;
  logic [DIV_W-1:0]   sat_lim;

  assign sat_lim = DIV_W'(norm_r) << 15;

  always_ff @(posedge clk) begin
    if (cmd.abs_dot) begin
      neg_r <= dot_r[ACC_W-1];
      a_r   <= dot_r[ACC_W-1] ? ACC_W'(-dot_r) : ACC_W'(dot_r);
    end
    if (cmd.div_init) begin
      rem_r <= DIV_W'(a_r) << 16;
      dv_r  <= DIV_W'(norm_r) << 30;
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (rem_r >= dv_r) begin
        rem_r <= rem_r - dv_r;
        q_r   <= {q_r[29:0], 1'b1};
      end else begin
        q_r <= {q_r[29:0], 1'b0};
      end
      dv_r <= dv_r >> 1;
    end
    if (cmd.t_sat) t_r <= neg_r ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else if (cmd.t_div) t_r <= neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.div_init || cmd.sqrt_init) begin
      step_r <= '0;
    end else if (cmd.div_step || cmd.sqrt_step) begin
      step_r <= step_r + 1'b1;
    end
  end

  // squared distance
  logic signed [48:0] diff;
  logic [48:0]        mag;
  logic [30:0]        m_r;
  logic               big_r;
  logic [61:0]        sq_r;
  logic [63:0]        sum_r, sum_add;
  logic               sum_sat_r;

  assign diff    = 49'($signed(prod_r[63:16])) - 49'(pk);
  assign mag     = diff[48] ? 49'(-diff) : 49'(diff);
  assign sum_add = sum_r + 64'(sq_r);

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      m_r   <= mag[30:0];
      big_r <= |mag[48:31];
    end
    if (cmd.sq) sq_r <= m_r * m_r;
    if (cmd.t_sat || cmd.t_div) begin
      sum_r     <= '0;
      sum_sat_r <= 1'b0;
    end else if (cmd.acc2 && !sum_sat_r) begin
      if (big_r || sum_add > SUM_CAP) begin
        sum_r     <= SUM_CAP;
        sum_sat_r <= 1'b1;
      end else begin
        sum_r <= sum_add;
      end
    end
  end

  // square root, one result bit per step
  logic [63:0] x_r, res_r, bit_r, trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      x_r   <= sum_r;
      res_r <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (cmd.sqrt_step) begin
      if (x_r >= trial) begin
        x_r   <= x_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // best reference
  logic               found_r;
  logic [REF_W-1:0]   best_r;
  logic [30:0]        best_d_r;
  logic signed [31:0] best_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.ref_init) begin
      found_r <= 1'b0;
    end else if (cmd.pick && (!found_r || res_r[30:0] < best_d_r)) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick && (!found_r || res_r[30:0] < best_d_r)) begin
      best_r   <= i_r[REF_W-1:0];
      best_d_r <= res_r[30:0];
      best_t_r <= t_r;
    end
  end

  // association counts: total, archive, front from low bits up
  logic [CW3-1:0]        cnt_mem [MAX_REFS];
  logic [CW3-1:0]        cnt_q;
  logic [REF_W:0]        clr_r;
  logic [COUNT_BITS-1:0] tot_c, arc_c, frn_c, tot_n, arc_n, frn_n;

  assign tot_c = cnt_q[COUNT_BITS-1:0];
  assign arc_c = cnt_q[2*COUNT_BITS-1:COUNT_BITS];
  assign frn_c = cnt_q[CW3-1:2*COUNT_BITS];
  assign tot_n = (tot_c == COUNT_MAX) ? tot_c : tot_c + 1'b1;
  assign arc_n = (arch_r && arc_c != COUNT_MAX) ? arc_c + 1'b1 : arc_c;
  assign frn_n = (!arch_r && frn_c != COUNT_MAX) ? frn_c + 1'b1 : frn_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_init) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      cnt_mem[clr_r[REF_W-1:0]] <= '0;
    end else if (cmd.cnt_upd) begin
      cnt_mem[best_r] <= {frn_n, arc_n, tot_n};
    end
    if (cmd.cnt_rd) cnt_q <= cnt_mem[best_r];
  end

  // result register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_empty || cmd.cnt_upd) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_empty) begin
      out_data_r <= '0;
      out_user_r <= 1'b1;
    end else if (cmd.cnt_upd) begin
      out_data_r <= {1'b0, 16'(frn_n), 16'(arc_n), 16'(tot_n), best_t_r, best_d_r, 8'(best_r)};
      out_user_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // status to controller
  always_comb begin
    sts           = '0;
    sts.in_valid  = in_tvalid;
    sts.in_req    = in_req;
    sts.in_last   = in_tlast;
    sts.clr_last  = (32'(clr_r) == MAX_REFS - 1);
    sts.ref_end   = (32'(i_r) >= 32'(ref_limit_r)) || (32'(i_r) >= MAX_REFS);
    sts.k_end     = (32'(k_r) >= 32'(num_obj_r)) || (32'(k_r) >= MAX_OBJ);
    sts.norm_zero = (norm_r == '0);
    sts.div_sat   = (DIV_W'(a_r) >= sat_lim);
    sts.div_last  = (step_r == 5'd30);
    sts.sqrt_last = (step_r == 5'd31);
    sts.found     = found_r;
    sts.out_free  = !out_valid_r || out_tready;
  end

endmodule
`default_nettype wire
